// File: design/power_table_cache_interpolator_top_macros.svh
// ----------------------------------------------------------------------------
// power table cache interpolator assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef POWER_TABLE_CACHE_INTERPOLATOR_TOP_MACROS_SVH
`define POWER_TABLE_CACHE_INTERPOLATOR_TOP_MACROS_SVH

// same-cycle implication, reset masks the check
`define PTCI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptci check failed");

// next-cycle implication, reset masks the check
`define PTCI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptci check failed");

`endif

// File: design/ptci_pkg.sv
// ----------------------------------------------------------------------------
// ptci_pkg
// shared constants, widths and controller/datapath handshake types
// ----------------------------------------------------------------------------
package ptci_pkg;

   localparam int MAX_EXPONENTS = 32;
   localparam int TABLE_POINTS  = 129;
   localparam int FRAC_BITS     = 16;

   localparam int X_W      = 17;
   localparam int EXP_W    = 8;
   localparam int VAL_W    = FRAC_BITS + 1;
   localparam int SEGMENTS = TABLE_POINTS - 1;
   localparam int SEG_BITS = $clog2(SEGMENTS);
   localparam int SLOT_W   = (MAX_EXPONENTS > 1) ? $clog2(MAX_EXPONENTS) : 1;
   localparam int USED_W   = $clog2(MAX_EXPONENTS + 1);
   localparam int PT_W     = $clog2(TABLE_POINTS);
   localparam int DEPTH    = MAX_EXPONENTS * TABLE_POINTS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int PROD_W   = 2 * VAL_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int WIDE_W   = VAL_W + SEG_BITS + 2;
   localparam int DIFF_SHIFT = (FRAC_BITS >= SEG_BITS) ? (FRAC_BITS - SEG_BITS) : 0;

   localparam int REQ_W  = 32;
   localparam int RSP_W  = 24;
   localparam int USER_W = 2;

   localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;

   typedef struct packed {
      logic load_in;
      logic slot_inc;
      logic tag_wr;
      logic fb_set;
      logic pow_init_x;
      logic pow_init_pt;
      logic pow_mul_r;
      logic pow_mul_b;
      logic pt_clr;
      logic pt_inc;
      logic ram_wr;
      logic used_inc;
      logic built_set;
      logic rd_a;
      logic rd_b;
      logic cap_a;
      logic res_ram;
      logic mul1;
      logic mul2;
      logic sum;
      logic res_pow;
      logic out_load;
   } ptci_cmd_type;

   typedef struct packed {
      logic hit;
      logic at_end;
      logic full;
      logic exp_zero;
      logic pt_last;
      logic top;
      logic rsp_busy;
   } ptci_status_type;

endpackage

// File: design/ptci_ram.sv
// ----------------------------------------------------------------------------
// ptci_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ptci_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 4128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ptci_datapath.sv
// ----------------------------------------------------------------------------
// ptci_datapath
// tag store, sample ram, shared multiplier, power and interpolation registers
// ----------------------------------------------------------------------------
module ptci_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ptci_pkg::REQ_W-1:0]          req_tdata,
   input  ptci_pkg::ptci_cmd_type              cmd,
   output ptci_pkg::ptci_status_type           status,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ptci_pkg::RSP_W-1:0]          rsp_tdata,
   output logic [ptci_pkg::USER_W-1:0]         rsp_tuser
);

   logic [ptci_pkg::VAL_W-1:0]  x_ff;
   logic [ptci_pkg::EXP_W-1:0]  n_ff;
   logic [ptci_pkg::USED_W-1:0] slot_ff;
   logic [ptci_pkg::USED_W-1:0] used_ff;
   logic [ptci_pkg::EXP_W-1:0]  tags_ff [ptci_pkg::MAX_EXPONENTS];
   logic [ptci_pkg::PT_W-1:0]   pt_ff;
   logic [ptci_pkg::VAL_W-1:0]  r_ff;
   logic [ptci_pkg::VAL_W-1:0]  b_ff;
   logic [ptci_pkg::EXP_W-1:0]  e_ff;
   logic [ptci_pkg::VAL_W-1:0]  va_ff;
   logic [ptci_pkg::VAL_W-1:0]  vb_ff;
   logic [ptci_pkg::PROD_W-1:0] acc_ff;
   logic [ptci_pkg::PROD_W-1:0] prod_ff;
   logic [ptci_pkg::VAL_W-1:0]  res_ff;
   logic                        from_ff;
   logic                        built_ff;
   logic                        rsp_valid_ff;
   logic [ptci_pkg::VAL_W-1:0]  rsp_val_ff;
   logic [ptci_pkg::USER_W-1:0] rsp_user_ff;

   logic [ptci_pkg::X_W-1:0]    x_raw;
   logic [ptci_pkg::VAL_W-1:0]  x_sat;
   logic [ptci_pkg::SLOT_W-1:0] slot_idx;
   logic [ptci_pkg::WIDE_W-1:0] a_wide;
   logic [ptci_pkg::SEG_BITS:0] seg_a;
   logic [ptci_pkg::SEG_BITS-1:0] a_idx;
   logic [ptci_pkg::WIDE_W-1:0] xa_wide;
   logic [ptci_pkg::WIDE_W-1:0] xb_wide;
   logic [ptci_pkg::WIDE_W-1:0] xs_wide;
   logic [ptci_pkg::VAL_W-1:0]  xa;
   logic [ptci_pkg::VAL_W-1:0]  xb;
   logic                        zero_seg;
   logic [ptci_pkg::VAL_W-1:0]  mul_a;
   logic [ptci_pkg::VAL_W-1:0]  mul_b;
   logic [ptci_pkg::PROD_W-1:0] mul_p;
   logic [ptci_pkg::VAL_W-1:0]  mul_q;
   logic [ptci_pkg::ACC_W-1:0]  num_sum;
   logic [ptci_pkg::ACC_W-1:0]  num_shift;
   logic [ptci_pkg::ADDR_W-1:0] base_addr;
   logic [ptci_pkg::ADDR_W-1:0] wr_addr;
   logic [ptci_pkg::ADDR_W-1:0] rd_addr;
   logic                        rd_en;
   logic [ptci_pkg::VAL_W-1:0]  rd_data;

   // base saturates at 1.0
   assign x_raw = req_tdata[ptci_pkg::X_W-1:0];
   assign x_sat = (x_raw > ptci_pkg::X_W'(ptci_pkg::ONE)) ? ptci_pkg::ONE
                                                          : ptci_pkg::VAL_W'(x_raw);

   assign slot_idx = slot_ff[ptci_pkg::SLOT_W-1:0];

   // segment index and its end points, all by shifts
   assign a_wide  = (ptci_pkg::WIDE_W'(x_ff) << ptci_pkg::SEG_BITS) >> ptci_pkg::FRAC_BITS;
   assign seg_a   = a_wide[ptci_pkg::SEG_BITS:0];
   assign a_idx   = seg_a[ptci_pkg::SEG_BITS-1:0];
   assign xa_wide = (ptci_pkg::WIDE_W'(a_idx) << ptci_pkg::FRAC_BITS) >> ptci_pkg::SEG_BITS;
   assign xb_wide = ((ptci_pkg::WIDE_W'(a_idx) + ptci_pkg::WIDE_W'(1)) << ptci_pkg::FRAC_BITS)
                    >> ptci_pkg::SEG_BITS;
   assign xs_wide = (ptci_pkg::WIDE_W'(pt_ff) << ptci_pkg::FRAC_BITS) >> ptci_pkg::SEG_BITS;
   assign xa       = xa_wide[ptci_pkg::VAL_W-1:0];
   assign xb       = xb_wide[ptci_pkg::VAL_W-1:0];
   assign zero_seg = (xb <= xa);

   // one shared multiplier
   always_comb begin
      mul_a = r_ff;
      mul_b = b_ff;
      if (cmd.pow_mul_b) begin
         mul_a = b_ff;
      end else if (cmd.mul1) begin
         mul_a = va_ff;
         mul_b = xb - x_ff;
      end else if (cmd.mul2) begin
         mul_a = vb_ff;
         mul_b = x_ff - xa;
      end
   end

   assign mul_p = ptci_pkg::PROD_W'(mul_a) * ptci_pkg::PROD_W'(mul_b);
   assign mul_q = mul_p[ptci_pkg::FRAC_BITS +: ptci_pkg::VAL_W];

   assign num_sum   = ptci_pkg::ACC_W'(acc_ff) + ptci_pkg::ACC_W'(prod_ff);
   assign num_shift = num_sum >> ptci_pkg::DIFF_SHIFT;

   assign base_addr = ptci_pkg::ADDR_W'(slot_idx) * ptci_pkg::ADDR_W'(ptci_pkg::TABLE_POINTS);
   assign wr_addr   = base_addr + ptci_pkg::ADDR_W'(pt_ff);

   always_comb begin
      rd_addr = base_addr + ptci_pkg::ADDR_W'(a_idx) + ptci_pkg::ADDR_W'(1);
      if (cmd.rd_a) begin
         rd_addr = status.top ? base_addr + ptci_pkg::ADDR_W'(ptci_pkg::SEGMENTS)
                              : base_addr + ptci_pkg::ADDR_W'(a_idx);
      end
   end

   assign rd_en = cmd.rd_a | (cmd.rd_b & ~status.top);

   ptci_ram #(
      .WIDTH (ptci_pkg::VAL_W),
      .DEPTH (ptci_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.ram_wr),
      .wr_addr (wr_addr),
      .wr_data (r_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.hit      = (tags_ff[slot_idx] == n_ff);
   assign status.at_end   = (slot_ff == used_ff);
   assign status.full     = (used_ff == ptci_pkg::USED_W'(ptci_pkg::MAX_EXPONENTS));
   assign status.exp_zero = (e_ff == '0);
   assign status.pt_last  = (pt_ff == ptci_pkg::PT_W'(ptci_pkg::SEGMENTS));
   assign status.top      = seg_a[ptci_pkg::SEG_BITS];
   assign status.rsp_busy = rsp_valid_ff & ~rsp_tready;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.used_inc) begin
            used_ff <= used_ff + ptci_pkg::USED_W'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         x_ff     <= x_sat;
         n_ff     <= req_tdata[ptci_pkg::X_W +: ptci_pkg::EXP_W];
         slot_ff  <= '0;
         from_ff  <= 1'b1;
         built_ff <= 1'b0;
      end
      if (cmd.slot_inc) begin
         slot_ff <= slot_ff + ptci_pkg::USED_W'(1);
      end
      if (cmd.tag_wr) begin
         tags_ff[slot_idx] <= n_ff;
      end
      if (cmd.fb_set) begin
         from_ff <= 1'b0;
      end
      if (cmd.built_set) begin
         built_ff <= 1'b1;
      end
      if (cmd.pt_clr) begin
         pt_ff <= '0;
      end else if (cmd.pt_inc) begin
         pt_ff <= pt_ff + ptci_pkg::PT_W'(1);
      end
      if (cmd.pow_init_x) begin
         b_ff <= x_ff;
         r_ff <= ptci_pkg::ONE;
         e_ff <= n_ff;
      end else if (cmd.pow_init_pt) begin
         b_ff <= xs_wide[ptci_pkg::VAL_W-1:0];
         r_ff <= ptci_pkg::ONE;
         e_ff <= n_ff;
      end else if (cmd.pow_mul_r) begin
         if (e_ff[0]) begin
            r_ff <= mul_q;
         end
      end else if (cmd.pow_mul_b) begin
         b_ff <= mul_q;
         e_ff <= e_ff >> 1;
      end
      if (cmd.cap_a) begin
         va_ff <= rd_data;
      end
      if (cmd.mul1) begin
         vb_ff  <= rd_data;
         acc_ff <= mul_p;
      end
      if (cmd.mul2) begin
         prod_ff <= mul_p;
      end
      if (cmd.res_pow) begin
         res_ff <= r_ff;
      end else if (cmd.res_ram) begin
         res_ff <= rd_data;
      end else if (cmd.sum) begin
         res_ff <= zero_seg ? va_ff : num_shift[ptci_pkg::VAL_W-1:0];
      end
      if (cmd.out_load) begin
         rsp_val_ff  <= res_ff;
         rsp_user_ff <= {built_ff, from_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ptci_pkg::RSP_W'(rsp_val_ff);
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: design/ptci_ctrl.sv
// ----------------------------------------------------------------------------
// ptci_ctrl
// sequencer: tag search, table build, power loop, interpolation, hand-off
// ----------------------------------------------------------------------------
module ptci_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  ptci_pkg::ptci_status_type status,
   output ptci_pkg::ptci_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_BLD,
      ST_POW_R,
      ST_POW_B,
      ST_RD_A,
      ST_RD_B,
      ST_MUL1,
      ST_MUL2,
      ST_SUM,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      fb_ff;
   logic      fb_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      fb_in    = fb_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               fb_in       = 1'b0;
               state_in    = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.at_end) begin
               if (status.full) begin
                  cmd.fb_set     = 1'b1;
                  cmd.pow_init_x = 1'b1;
                  fb_in          = 1'b1;
                  state_in       = ST_POW_R;
               end else begin
                  cmd.tag_wr = 1'b1;
                  cmd.pt_clr = 1'b1;
                  state_in   = ST_BLD;
               end
            end else if (status.hit) begin
               state_in = ST_RD_A;
            end else begin
               cmd.slot_inc = 1'b1;
            end
         end
         ST_BLD: begin
            cmd.pow_init_pt = 1'b1;
            state_in        = ST_POW_R;
         end
         ST_POW_R: begin
            if (!status.exp_zero) begin
               cmd.pow_mul_r = 1'b1;
               state_in      = ST_POW_B;
            end else if (fb_ff) begin
               cmd.res_pow = 1'b1;
               state_in    = ST_DONE;
            end else begin
               cmd.ram_wr = 1'b1;
               if (status.pt_last) begin
                  cmd.used_inc  = 1'b1;
                  cmd.built_set = 1'b1;
                  state_in      = ST_RD_A;
               end else begin
                  cmd.pt_inc = 1'b1;
                  state_in   = ST_BLD;
               end
            end
         end
         ST_POW_B: begin
            cmd.pow_mul_b = 1'b1;
            state_in      = ST_POW_R;
         end
         ST_RD_A: begin
            cmd.rd_a = 1'b1;
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.rd_b  = 1'b1;
            cmd.cap_a = 1'b1;
            // x at 1.0 takes the last sample as is
            if (status.top) begin
               cmd.res_ram = 1'b1;
               state_in    = ST_DONE;
            end else begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fb_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fb_ff    <= fb_in;
      end
   end

endmodule

// File: design/power_table_cache_interpolator_top.sv
// ----------------------------------------------------------------------------
// power_table_cache_interpolator_top
// x^n in q1.16 from cached per-exponent sample tables with linear interpolation
// ----------------------------------------------------------------------------
// req channel: one beat carries x_value (q1.16, saturated at 1.0) and exponent.
// rsp channel: one beat per request with power_value, from_table, table_built.
// one request is in work at a time; a new request is taken while the previous
// result still sits in the rsp output register.
// hit path: the search steps through the slots up to the matching one, then
//    the sample ram reads (registered read port), two multiplies and the sum.
//    x at 1.0 skips the multiplies.
// new exponent with a free slot: search over all used slots, then 129
//    samples, each computed by the squaring loop on the single shared 17x17
//    multiplier, then the hit path.
// cache full and new exponent: search, direct squaring of x to the power n,
//    then the output.
// reset empties the tag cache; sample ram contents are not cleared.
// a stalled rsp holds its beat; the block then finishes the next request and
// waits with it until the output register frees.
// ----------------------------------------------------------------------------
module power_table_cache_interpolator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ptci_pkg::REQ_W-1:0]          req_tdata,  // x_value[16:0], exponent[24:17]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ptci_pkg::RSP_W-1:0]          rsp_tdata,  // power_value[16:0]
   output logic [ptci_pkg::USER_W-1:0]         rsp_tuser   // from_table[0], table_built[1]
);

   ptci_pkg::ptci_cmd_type    cmd;
   ptci_pkg::ptci_status_type status;

   ptci_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ptci_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: design/ptci_checker.sv
// ----------------------------------------------------------------------------
// ptci_checker
// port-level checks on the request and result channels, bound to the top level
// ----------------------------------------------------------------------------
`include "power_table_cache_interpolator_top_macros.svh"

module ptci_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [ptci_pkg::REQ_W-1:0]  req_tdata,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [ptci_pkg::RSP_W-1:0]  rsp_tdata,
   input logic [ptci_pkg::USER_W-1:0] rsp_tuser
);

   logic req_beat;
   logic [ptci_pkg::VAL_W-1:0] rsp_val;

   assign req_beat = req_tvalid & req_tready & (req_tdata != '1);
   assign rsp_val  = rsp_tdata[ptci_pkg::VAL_W-1:0];

   `PTCI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `PTCI_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser))
   `PTCI_ASSERT_NOW(a_val_range, clock, reset, rsp_tvalid, rsp_val <= ptci_pkg::ONE)
   `PTCI_ASSERT_NOW(a_built_table, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0])
   `PTCI_ASSERT_NEXT(a_busy_after_req, clock, reset, req_beat, !req_tready)

endmodule

bind power_table_cache_interpolator_top ptci_checker u_ptci_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
